// ===== sv/psmc_pkg.sv =====
`default_nettype none

package psmc_pkg;

    localparam int ADDR_W  = 64;
    localparam int COUNT_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_ONE = {{(COUNT_W-1){1'b0}}, 1'b1};

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [COUNT_W-1:0] t_count;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE
    } t_state;

    // control broadcast to every cell
    typedef struct packed {
        logic compare;  // lookup cycle: cells compare the held address
        logic commit;   // update cycle: cells write back
        logic miss;     // no cell matched the held address
    } t_cell_ctrl;

    // saturating increment of a sender count
    function automatic t_count sat_inc(input t_count value);
        t_count res;
        if (value == COUNT_MAX) begin
            res = COUNT_MAX;
        end else begin
            res = value + COUNT_ONE;
        end
        return res;
    endfunction

endpackage : psmc_pkg

`default_nettype wire

// ===== sv/psmc_cell.sv =====
`default_nettype none

module psmc_cell
    import psmc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cell_ctrl i_ctrl,
    input  wire t_addr      i_addr_high,
    input  wire t_addr      i_addr_low,
    input  wire logic       i_prev_valid,   // left neighbor is occupied
    output logic            o_valid,
    output logic            o_match,
    output t_count          o_sel_count      // next count when matched, else zero
);

    logic   r_valid;
    logic   r_match;
    t_addr  r_addr_high;
    t_addr  r_addr_low;
    t_count r_count;
    t_count r_sel_count;
    logic   n_match;
    logic   w_insert;

    assign n_match  = r_valid && (r_addr_high == i_addr_high) && (r_addr_low == i_addr_low);
    // entries fill in order, so the first empty cell sits right after an occupied one
    assign w_insert = i_ctrl.commit && i_ctrl.miss && i_prev_valid && !r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctrl.compare) begin
                r_match <= n_match;
            end else if (i_ctrl.commit) begin
                r_match <= 1'b0;
            end
            if (w_insert) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.compare) begin
            r_sel_count <= n_match ? sat_inc(r_count) : '0;
        end
        if (w_insert) begin
            r_addr_high <= i_addr_high;
            r_addr_low  <= i_addr_low;
            r_count     <= COUNT_ONE;
        end else if (i_ctrl.commit && r_match) begin
            r_count <= r_sel_count;
        end
    end

    assign o_valid     = r_valid;
    assign o_match     = r_match;
    assign o_sel_count = r_match ? r_sel_count : '0;

endmodule : psmc_cell

`default_nettype wire

// ===== sv/per_sender_message_counter_unit.sv =====
// per-sender message counter
// input stream: one transfer per received message, tdata carries the 128-bit
// sender address (addr_high in bits 63:0, addr_low in bits 127:64)
// output stream: one transfer per input transfer, in order; tdata carries the
// sender's saturating count and the wrapping total, tuser the new-sender and
// table-full flags
// the table is a row of TABLE_ENTRIES cells, each holding one sender address,
// its count and a valid bit; every cell compares the held address at once,
// and an unknown sender goes into the first empty cell, found from the
// neighbor's valid bit
// an item passes the compare state, then the update state, whose commit
// fills the output register; items go through the compare / update sequence
// of the cell row one at a time; the next item is taken on commit or while idle
// when the receiver stalls, the finished result waits in the output register;
// the following item finishes its compare, then holds in the update stage with
// tready low until the register frees
// reset: synchronous active low, empties the table, clears the total and
// drops both tvalid and tready-side state
`default_nettype none

module per_sender_message_counter_unit
    import psmc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // input stream
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [127:0] i_s_axis_tdata,   // addr_high[63:0], addr_low[127:64]
    // output stream
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [63:0]       o_m_axis_tdata,   // sender_count[31:0], total_count[63:32]
    output logic [1:0]        o_m_axis_tuser    // new_sender[0], table_full[1]
);

    t_state     r_state;
    t_state     n_state;
    t_cell_ctrl w_ctrl;

    // held item
    t_addr      r_addr_high;
    t_addr      r_addr_low;

    // running total of all messages
    t_count     r_total;

    // output register
    logic       r_out_valid;
    t_count     r_out_count;
    t_count     r_out_total;
    logic       r_out_new;
    logic       r_out_full;

    logic       w_in_xfer;
    logic       w_commit;
    logic       w_hit;
    logic       w_full;
    t_count     w_sel_count;

    logic   [TABLE_ENTRIES-1:0] w_valid;
    logic   [TABLE_ENTRIES-1:0] w_match;
    t_count                     w_cell_count [TABLE_ENTRIES];

    // result leaves the update stage only when the output register is free
    assign w_commit  = (r_state == ST_UPDATE) && (!r_out_valid || i_m_axis_tready);
    assign w_in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) n_state = ST_MATCH;
            end
            ST_MATCH: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (w_commit) n_state = w_in_xfer ? ST_MATCH : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_ctrl.compare  = 1'b0;
        w_ctrl.commit   = 1'b0;
        w_ctrl.miss     = !w_hit;
        unique case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
            end
            ST_MATCH: begin
                w_ctrl.compare = 1'b1;
            end
            ST_UPDATE: begin
                o_s_axis_tready = w_commit;
                w_ctrl.commit   = w_commit;
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_addr_high <= i_s_axis_tdata[63:0];
            r_addr_low  <= i_s_axis_tdata[127:64];
        end
    end

    // cell row; cell 0 sees an always-occupied left neighbor
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        logic w_prev_valid;
        if (g == 0) begin : g_head
            assign w_prev_valid = 1'b1;
        end else begin : g_link
            assign w_prev_valid = w_valid[g-1];
        end
        psmc_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_addr_high  (r_addr_high),
            .i_addr_low   (r_addr_low),
            .i_prev_valid (w_prev_valid),
            .o_valid      (w_valid[g]),
            .o_match      (w_match[g]),
            .o_sel_count  (w_cell_count[g])
        );
    end

    // at most one cell matches, so an or of the gated counts picks it
    always_comb begin
        w_sel_count = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            w_sel_count = w_sel_count | w_cell_count[i];
        end
    end

    assign w_hit  = |w_match;
    assign w_full = w_valid[TABLE_ENTRIES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_commit) begin
                r_total     <= r_total + COUNT_ONE;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_total <= r_total + COUNT_ONE;
            r_out_new   <= !w_hit;
            r_out_full  <= !w_hit && w_full;
            if (w_hit) begin
                r_out_count <= w_sel_count;
            end else if (w_full) begin
                r_out_count <= '0;
            end else begin
                r_out_count <= COUNT_ONE;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_total, r_out_count};
    assign o_m_axis_tuser  = {r_out_full, r_out_new};

endmodule : per_sender_message_counter_unit

`default_nettype wire

// ===== dv/tb_per_sender_message_counter_unit.sv =====
`timescale 1ns / 100ps

module tb_per_sender_message_counter_unit;
    import psmc_pkg::*;

    localparam int SLOTS          = 64;
    localparam int IDLE_LIMIT     = 1000;  // cycles with no transfer on either side
    localparam int DRAIN_CYCLES   = 20;
    localparam int POOL_CAP       = 256;
    localparam int RANDOM_HALF    = 400;

    // one expected output transfer
    typedef struct packed {
        t_count sender_count;
        t_count total_count;
        logic   new_sender;
        logic   table_full;
    } t_tally;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #1 i_clk = ~i_clk;

    // stream signals; the ones the testbench drives are known from time zero
    logic         s_tvalid = 1'b0;
    logic [127:0] s_tdata  = '0;   // addr_high[63:0], addr_low[127:64]
    logic         s_tready;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;         // sender_count[31:0], total_count[63:32]
    logic [1:0]   m_tuser;         // new_sender[0], table_full[1]

    per_sender_message_counter_unit #(
        .TABLE_ENTRIES (SLOTS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------
    // sender table as the testbench sees it
    // ------------------------------------------------------------------
    t_addr  sender_high  [SLOTS];
    t_addr  sender_low   [SLOTS];
    logic   sender_known [SLOTS];
    t_count sender_tally [SLOTS];
    int     slots_used    = 0;
    t_count messages_seen = '0;

    t_tally expected_tallies [$];
    int     fail_count = 0;

    // addresses already sent, so random traffic can hit them again
    t_addr pool_high [$];
    t_addr pool_low  [$];

    // sender burst / gap bookkeeping
    int burst_left = 0;

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            sender_known[i] = 1'b0;
        end
    end

    // lookup, count update and insert for one message
    // note: count saturation and total wrap need 2^32 messages, beyond any run
    function automatic t_tally tally_message(input t_addr hi, input t_addr lo);
        t_tally r;
        logic   hit;
        r   = '0;
        hit = 1'b0;
        messages_seen = messages_seen + 1'b1;
        r.total_count = messages_seen;
        // only occupied slots take part, so the zero address never hits an empty one
        for (int i = 0; i < SLOTS; i++) begin
            if (!hit && sender_known[i] && sender_high[i] == hi && sender_low[i] == lo) begin
                if (sender_tally[i] != COUNT_MAX) begin
                    sender_tally[i] = sender_tally[i] + 1'b1;
                end
                r.sender_count = sender_tally[i];
                hit = 1'b1;
            end
        end
        if (!hit) begin
            r.new_sender = 1'b1;
            if (slots_used < SLOTS) begin
                sender_high[slots_used]  = hi;
                sender_low[slots_used]   = lo;
                sender_tally[slots_used] = 1;
                sender_known[slots_used] = 1'b1;
                slots_used               = slots_used + 1;
                r.sender_count           = 1;
            end else begin
                // full table: flagged, not stored, count reads zero
                r.table_full   = 1'b1;
                r.sender_count = '0;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // input side: one address per transfer, bursts with random gaps
    // ------------------------------------------------------------------
    task automatic send_address(input t_addr hi, input t_addr lo);
        int     gap;
        t_tally r;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left = burst_left - 1;
        s_tvalid <= 1'b1;
        s_tdata  <= {lo, hi};
        do begin
            @(posedge i_clk);
        end while (!s_tready);
        r = tally_message(hi, lo);
        expected_tallies.push_back(r);
        if (r.new_sender && pool_high.size() < POOL_CAP) begin
            pool_high.push_back(hi);
            pool_low.push_back(lo);
        end
    endtask

    // fresh-looking address, often a near neighbor of one already seen
    task automatic make_fresh_address(output t_addr hi, output t_addr lo);
        int k;
        int b;
        hi = {$urandom, $urandom};
        lo = {$urandom, $urandom};
        if (pool_high.size() != 0) begin
            k = $urandom_range(0, pool_high.size() - 1);
            b = $urandom_range(0, 63);
            case ($urandom_range(0, 4))
                0: begin
                    // one bit away in the upper half
                    hi = pool_high[k] ^ (t_addr'(1) << b);
                    lo = pool_low[k];
                end
                1: begin
                    // one bit away in the lower half
                    hi = pool_high[k];
                    lo = pool_low[k] ^ (t_addr'(1) << b);
                end
                2: begin
                    // same upper half, different lower half
                    hi = pool_high[k];
                end
                3: begin
                    // one half at an extreme
                    if ($urandom_range(0, 1) == 0) begin
                        hi = ($urandom_range(0, 1) == 0) ? '0 : '1;
                    end else begin
                        lo = ($urandom_range(0, 1) == 0) ? '0 : '1;
                    end
                end
                default: begin
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // extremes of both halves, halves told apart, first hits
    task automatic test_edge_addresses();
        send_address('0, '0);                      // zero address must not hit an empty slot
        send_address('0, '0);
        send_address('1, '1);
        send_address('0, 64'd1);
        send_address(64'd1, '0);                   // halves swapped
        send_address(64'h8000_0000_0000_0000, '0);
        send_address('0, 64'h8000_0000_0000_0000);
        send_address('1, '0);
        send_address('0, '1);
        send_address('1, '1);
        send_address('0, '0);
        send_address(64'd1, '0);
        send_address(64'hA5A5_5A5A_0F0F_F0F0, 64'h5A5A_A5A5_F0F0_0F0F);
        send_address(64'h5A5A_A5A5_F0F0_0F0F, 64'hA5A5_5A5A_0F0F_F0F0);
    endtask

    // mostly repeat senders, the rest new or near misses
    task automatic test_random_traffic(input int n);
        t_addr hi;
        t_addr lo;
        int    k;
        for (int j = 0; j < n; j++) begin
            if (pool_high.size() != 0 && $urandom_range(0, 99) < 70) begin
                k  = $urandom_range(0, pool_high.size() - 1);
                hi = pool_high[k];
                lo = pool_low[k];
            end else begin
                make_fresh_address(hi, lo);
            end
            send_address(hi, lo);
        end
    endtask

    // fill every slot, then new senders are rejected while known ones still count
    task automatic test_table_full();
        t_addr hi;
        t_addr lo;
        while (slots_used < SLOTS) begin
            make_fresh_address(hi, lo);
            send_address(hi, lo);
        end
        repeat (3) begin
            make_fresh_address(hi, lo);
            send_address(hi, lo);
        end
        send_address(hi, lo);                      // rejected sender stays unknown
        send_address('0, '0);                      // stored sender still counts
        send_address(sender_high[SLOTS-1], sender_low[SLOTS-1]);
    endtask

    // ------------------------------------------------------------------
    // output side: stall pattern redrawn when its 6-bit age counter wraps, rotated in all other cycles
    // ------------------------------------------------------------------
    logic [15:0] ready_pattern = 16'hFFFF;
    logic [5:0]  pattern_age   = '0;

    always @(posedge i_clk) begin : rx_stall
        logic [15:0] next_pattern;
        next_pattern = {ready_pattern[0], ready_pattern[15:1]};
        if (pattern_age == '0) begin
            case ($urandom_range(0, 3))
                0: next_pattern = 16'hFFFF;                     // no stalls
                1: next_pattern = 16'($urandom) | 16'h0001;
                2: next_pattern = 16'($urandom | $urandom) | 16'h0001;
                default: next_pattern = 16'($urandom & $urandom) | 16'h0001;
            endcase
        end
        pattern_age   <= pattern_age + 1'b1;
        ready_pattern <= next_pattern;
        m_tready      <= next_pattern[0];
    end

    // ------------------------------------------------------------------
    // result check: each output transfer against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_tally want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_tallies.size() == 0) begin
                $error("output transfer with no expectation pending");
                fail_count = fail_count + 1;
            end else begin
                want = expected_tallies.pop_front();
                if (m_tdata[31:0] !== want.sender_count) begin
                    $error("sender_count: expected %0d, actual %0d",
                           want.sender_count, m_tdata[31:0]);
                    fail_count = fail_count + 1;
                end
                if (m_tdata[63:32] !== want.total_count) begin
                    $error("total_count: expected %0d, actual %0d",
                           want.total_count, m_tdata[63:32]);
                    fail_count = fail_count + 1;
                end
                if (m_tuser[0] !== want.new_sender) begin
                    $error("new_sender: expected %0b, actual %0b",
                           want.new_sender, m_tuser[0]);
                    fail_count = fail_count + 1;
                end
                if (m_tuser[1] !== want.table_full) begin
                    $error("table_full: expected %0b, actual %0b",
                           want.table_full, m_tuser[1]);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // watchdog: too long without any transfer means the block is stuck
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_addresses();
        test_random_traffic(RANDOM_HALF);
        test_table_full();
        test_random_traffic(RANDOM_HALF);

        s_tvalid <= 1'b0;
        while (expected_tallies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/psmc_pkg.sv
sv/psmc_cell.sv
sv/per_sender_message_counter_unit.sv
dv/tb_per_sender_message_counter_unit.sv
